[rtl/core/dtoi_pkg.sv]
// ----------------------------------------------------------------------------
// dtoi_pkg
// Shared types and codes for the decimal text to int64 converter.
// ----------------------------------------------------------------------------
package dtoi_pkg;

    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 3;
    localparam int PHASE_W  = 2;
    localparam int WIDE_W   = VALUE_W + 4;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [PHASE_W-1:0] PH_FIRST  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_MINUS  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_ZERO   = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DIGITS = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

    localparam logic [WIDE_W-1:0] MAG_MAX_POS = {4'h0, 64'h7FFF_FFFF_FFFF_FFFF};
    localparam logic [WIDE_W-1:0] MAG_MAX_NEG = {4'h0, 64'h8000_0000_0000_0000};

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              empty_word;
    } t_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [STATUS_W-1:0]       status;
    } t_result;

endpackage

[rtl/core/dtoi_in_reg.sv]
// ----------------------------------------------------------------------------
// dtoi_in_reg
// Input register: holds one character transfer until the parser takes it.
// ----------------------------------------------------------------------------
module dtoi_in_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  dtoi_pkg::t_item  i_item,
    input  logic             i_go,
    output logic             o_valid,
    output dtoi_pkg::t_item  o_item
);

    logic            r_valid;
    logic            n_valid;
    dtoi_pkg::t_item r_item;
    logic            w_take;

    assign o_stall = r_valid && !i_go;
    assign w_take  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_go) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/core/dtoi_parse.sv]
// ----------------------------------------------------------------------------
// dtoi_parse
// Word state and one-character step: sign, leading zero, multiply-add by ten
// with limit check, sticky first error, result on a last or empty-word transfer.
// ----------------------------------------------------------------------------
module dtoi_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  dtoi_pkg::t_item   i_item,
    input  logic              i_out_free,
    output logic              o_go,
    output logic              o_load,
    output dtoi_pkg::t_result o_result
);

    logic [dtoi_pkg::VALUE_W-1:0]  r_mag;
    logic                          r_neg;
    logic [dtoi_pkg::PHASE_W-1:0]  r_phase;
    logic [dtoi_pkg::STATUS_W-1:0] r_err;

    logic [dtoi_pkg::VALUE_W-1:0]  n_mag;
    logic                          n_neg;
    logic [dtoi_pkg::PHASE_W-1:0]  n_phase;
    logic [dtoi_pkg::STATUS_W-1:0] n_err;

    logic [dtoi_pkg::VALUE_W-1:0]  s_mag;
    logic                          s_neg;
    logic [dtoi_pkg::PHASE_W-1:0]  s_phase;
    logic [dtoi_pkg::STATUS_W-1:0] s_err;

    logic                          w_res;
    logic                          w_is_digit;
    logic [dtoi_pkg::CHAR_W-1:0]   w_c;
    logic [3:0]                    w_d;
    logic [dtoi_pkg::WIDE_W-1:0]   w_base;
    logic [dtoi_pkg::WIDE_W-1:0]   w_prod;
    logic [dtoi_pkg::WIDE_W-1:0]   w_limit;
    logic                          w_over;
    logic                          w_first_digit;

    assign w_c        = i_item.character;
    assign w_res      = i_item.last || i_item.empty_word;
    assign o_go       = i_valid && (!w_res || i_out_free);
    assign o_load     = o_go && w_res;
    assign w_is_digit = (w_c >= dtoi_pkg::CH_ZERO) && (w_c <= dtoi_pkg::CH_NINE);
    assign w_d        = 4'(w_c - dtoi_pkg::CH_ZERO);

    assign w_first_digit = (r_phase == dtoi_pkg::PH_FIRST) || (r_phase == dtoi_pkg::PH_MINUS);
    assign w_base  = w_first_digit ? '0 : {4'h0, r_mag};
    assign w_prod  = (w_base << 3) + (w_base << 1) + {{(dtoi_pkg::WIDE_W-4){1'b0}}, w_d};
    assign w_limit = r_neg ? dtoi_pkg::MAG_MAX_NEG : dtoi_pkg::MAG_MAX_POS;
    assign w_over  = w_prod > w_limit;

    always_comb begin
        s_mag   = r_mag;
        s_neg   = r_neg;
        s_phase = r_phase;
        s_err   = r_err;
        if (i_item.empty_word) begin
            if (r_phase == dtoi_pkg::PH_FIRST && r_err == dtoi_pkg::ST_OK) begin
                s_err = dtoi_pkg::ST_EMPTY;
            end
        end else if (r_err == dtoi_pkg::ST_OK) begin
            case (r_phase)
                dtoi_pkg::PH_FIRST, dtoi_pkg::PH_MINUS: begin
                    if (r_phase == dtoi_pkg::PH_FIRST && w_c == dtoi_pkg::CH_MINUS) begin
                        s_neg   = 1'b1;
                        s_phase = dtoi_pkg::PH_MINUS;
                    end else if (r_phase == dtoi_pkg::PH_FIRST && w_c == dtoi_pkg::CH_PLUS) begin
                        s_err = dtoi_pkg::ST_INVALID;
                    end else if (w_c == dtoi_pkg::CH_ZERO) begin
                        s_phase = dtoi_pkg::PH_ZERO;
                    end else begin
                        s_phase = dtoi_pkg::PH_DIGITS;
                        if (!w_is_digit) begin
                            s_err = dtoi_pkg::ST_INVALID;
                        end else if (w_over) begin
                            s_err = dtoi_pkg::ST_OVERFLOW;
                        end else begin
                            s_mag = w_prod[dtoi_pkg::VALUE_W-1:0];
                        end
                    end
                end
                dtoi_pkg::PH_ZERO: begin
                    s_err = dtoi_pkg::ST_ZERO;
                end
                default: begin
                    if (!w_is_digit) begin
                        s_err = dtoi_pkg::ST_INVALID;
                    end else if (w_over) begin
                        s_err = dtoi_pkg::ST_OVERFLOW;
                    end else begin
                        s_mag = w_prod[dtoi_pkg::VALUE_W-1:0];
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_result.value = '0;
        if (s_err != dtoi_pkg::ST_OK) begin
            o_result.status = s_err;
        end else if (s_phase == dtoi_pkg::PH_MINUS) begin
            o_result.status = dtoi_pkg::ST_INVALID;
        end else if (s_phase == dtoi_pkg::PH_FIRST) begin
            o_result.status = dtoi_pkg::ST_EMPTY;
        end else begin
            o_result.status = dtoi_pkg::ST_OK;
            o_result.value  = s_neg ? -s_mag : s_mag;
        end
    end

    always_comb begin
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_phase = r_phase;
        n_err   = r_err;
        if (o_go) begin
            if (w_res) begin
                n_mag   = '0;
                n_neg   = 1'b0;
                n_phase = dtoi_pkg::PH_FIRST;
                n_err   = dtoi_pkg::ST_OK;
            end else begin
                n_mag   = s_mag;
                n_neg   = s_neg;
                n_phase = s_phase;
                n_err   = s_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag   <= '0;
            r_neg   <= 1'b0;
            r_phase <= dtoi_pkg::PH_FIRST;
            r_err   <= dtoi_pkg::ST_OK;
        end else begin
            r_mag   <= n_mag;
            r_neg   <= n_neg;
            r_phase <= n_phase;
            r_err   <= n_err;
        end
    end

endmodule

[rtl/core/dtoi_out_reg.sv]
// ----------------------------------------------------------------------------
// dtoi_out_reg
// Result register: holds one result until the downstream transfer completes.
// ----------------------------------------------------------------------------
module dtoi_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  dtoi_pkg::t_result i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_stall,
    output dtoi_pkg::t_result o_result
);

    logic              r_valid;
    logic              n_valid;
    dtoi_pkg::t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[rtl/core/decimal_text_to_int64_unit.sv]
// ----------------------------------------------------------------------------
// decimal_text_to_int64_unit
// Streaming decimal text to signed 64-bit converter.
// ----------------------------------------------------------------------------
// One character transfer is taken every clock cycle while o_stall is low. Each
// character sits in the input register while the parser applies the
// sign, leading-zero and digit rules and a multiply-by-ten add with a limit
// compare to the word state; the transfer marked last (or empty word) loads
// the result register as the parser takes it, so a result passes through the
// input register and then the result register before it is offered downstream.
// A held result stalls the input only once both registers are full. The rate is
// set by the combinational update of the 64-bit magnitude for each character.
// ----------------------------------------------------------------------------
module decimal_text_to_int64_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [dtoi_pkg::CHAR_W-1:0]           i_character,
    input  logic                                  i_last,
    input  logic                                  i_empty_word,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [dtoi_pkg::VALUE_W-1:0]   o_value,
    output logic [dtoi_pkg::STATUS_W-1:0]         o_status
);

    dtoi_pkg::t_item   w_in_item;
    dtoi_pkg::t_item   w_a_item;
    dtoi_pkg::t_result w_res;
    dtoi_pkg::t_result w_out;
    logic              w_a_valid;
    logic              w_go;
    logic              w_load;
    logic              w_free;

    assign w_in_item.character  = i_character;
    assign w_in_item.last       = i_last;
    assign w_in_item.empty_word = i_empty_word;

    dtoi_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (w_in_item),
        .i_go    (w_go),
        .o_valid (w_a_valid),
        .o_item  (w_a_item)
    );

    dtoi_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_a_valid),
        .i_item     (w_a_item),
        .i_out_free (w_free),
        .o_go       (w_go),
        .o_load     (w_load),
        .o_result   (w_res)
    );

    dtoi_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_result (w_res),
        .o_free   (w_free),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (w_out)
    );

    assign o_value  = w_out.value;
    assign o_status = w_out.status;

endmodule
